@@ src/sfa_pkg.sv @@
// Shared types and constants of the sprite frame animator.
package sfa_pkg;

  // Input item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_LOAD    = 3'd1;
  localparam logic [2:0] KIND_PLAY    = 3'd2;
  localparam logic [2:0] KIND_STOP    = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_PERIOD = 3'd0;
  localparam logic [2:0] CFG_LOOP_ENABLE  = 3'd1;
  localparam logic [2:0] CFG_SHEET_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SHEET_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_TILE_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_TILE_HEIGHT  = 3'd5;
  localparam logic [2:0] CFG_MARGIN_X     = 3'd6;
  localparam logic [2:0] CFG_MARGIN_Y     = 3'd7;

  localparam int CFG_DATA_W = 16;

  // Divider: dividend covers the widest tile number, divisor the tile pitch
  localparam int DIV_W = 16;
  localparam int DVS_W = 14;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [22:0] Y_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_NX,
    ST_TILE,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

@@ src/sfa_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module sfa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sfa_pkg::div_req_t req,
  output sfa_pkg::div_rsp_t rsp
);
  import sfa_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quot_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] divisor_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quot_r[DIV_W-1]};
    diff    = shifted - {1'b0, divisor_r};
    ge      = shifted >= {1'b0, divisor_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r    <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIV_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

@@ src/sprite_frame_animator.sv @@
// Sprite-sheet frame animator: frame timing, frame-order table and tile position.
//
// Play, stop, restart, order-table loads and invisible ticks end on acceptance.
// A visible tick updates the frame timer and position in its accept cycle while
// playing, reads the frame-order memory, then runs two 16-step divisions on one
// bit-serial divider (tiles per row, then tile row and column), a multiply and a
// sum; bad geometry or no whole tile per row gives position zero. The input
// stalls while a tick is in flight; a finished result waits in the output
// register while the next item is taken. Order-table entries never loaded read
// as zero through per-entry valid bits; there is no clearing pass after reset.
module sprite_frame_animator #(
  parameter int ORDER_SLOTS = 256,
  parameter int TILE_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_elapsed,
  input  logic        in_visible,
  input  logic [7:0]  in_entry_slot,
  input  logic [9:0]  in_entry_tile,
  input  logic        in_entry_final,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_tile_x,
  output logic [22:0] out_tile_y,
  output logic [7:0]  out_frame_position,
  output logic        out_running
);
  import sfa_pkg::*;

  localparam int          DEPTH    = (ORDER_SLOTS < 256) ? ORDER_SLOTS : 256;
  localparam int          AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [12:0] SLOT_LIM = 13'(ORDER_SLOTS);

  // Configuration
  logic [15:0] frame_period_r;
  logic        loop_enable_r;
  logic [12:0] sheet_width_r;
  logic [12:0] sheet_height_r;
  logic [12:0] tile_width_r;
  logic [12:0] tile_height_r;
  logic [7:0]  margin_x_r;
  logic [7:0]  margin_y_r;

  // Animation state
  logic [17:0] time_left_r;
  logic [7:0]  frame_pos_r;
  logic [8:0]  order_length_r;
  logic        playing_r;

  // Frame-order memory
  logic [TILE_BITS-1:0] order_mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  logic [TILE_BITS-1:0] rd_tile_r;
  logic                 rd_ok_r;

  state_t state_r, state_nxt;

  logic        in_acc;
  logic        is_tick;
  logic        is_load;
  logic        slot_ok;

  logic [18:0] tl_diff;
  logic [17:0] tl_sat;
  logic [17:0] tl_new;
  logic        tl_adv;
  logic        pos_end;

  logic [13:0] dx;
  logic [13:0] dy;
  logic        geom_bad;
  logic        nx_zero;
  logic        mem_rd;
  logic        out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DIV_W-1:0] tile_q_r;
  logic [12:0]      tile_r_r;
  logic [26:0]      x_prod_r;
  logic [29:0]      y_prod_r;
  logic [26:0]      x_sum;
  logic [30:0]      y_sum;
  logic [12:0]      res_x_r;
  logic [22:0]      res_y_r;

  logic        out_valid_r;
  logic [12:0] out_tile_x_r;
  logic [22:0] out_tile_y_r;
  logic [7:0]  out_frame_position_r;
  logic        out_running_r;

  sfa_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_acc  = in_valid && !in_stall;
  assign is_tick = in_kind == KIND_TICK;
  assign is_load = in_kind == KIND_LOAD;
  assign slot_ok = {5'b0, in_entry_slot} < SLOT_LIM;

  // Frame timer: subtract with floor, add the period back on expiry
  always_comb begin
    tl_diff = {time_left_r[17], time_left_r} - {3'b000, in_elapsed};
    tl_sat  = (tl_diff[18] && !tl_diff[17]) ? 18'h20000 : tl_diff[17:0];
    tl_adv  = tl_sat[17] || (tl_sat == '0);
    tl_new  = tl_adv ? (tl_sat + {2'b00, frame_period_r}) : tl_sat;
    pos_end = ({1'b0, frame_pos_r} + 9'd1) >= order_length_r;
  end

  always_comb begin
    dx       = {1'b0, tile_width_r} + {6'b0, margin_x_r};
    dy       = {1'b0, tile_height_r} + {6'b0, margin_y_r};
    geom_bad = (tile_width_r > sheet_width_r) || (tile_height_r > sheet_height_r)
               || (dx == '0);
    nx_zero  = div_rsp.quot == '0;
    out_free = !out_valid_r || !out_stall;
    x_sum    = x_prod_r + {19'b0, margin_x_r};
    y_sum    = {1'b0, y_prod_r} + {23'b0, margin_y_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_tick && in_visible) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = geom_bad ? ST_OUT : ST_NX;
      ST_NX: begin
        if (div_rsp.done) state_nxt = nx_zero ? ST_OUT : ST_TILE;
      end
      ST_TILE: begin
        if (div_rsp.done) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall         = 1'b1;
    mem_rd           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(sheet_width_r);
    div_req.divisor  = dx;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: begin
        mem_rd        = 1'b1;
        div_req.start = !geom_bad;
      end
      ST_NX: begin
        div_req.start    = div_rsp.done && !nx_zero;
        div_req.dividend = rd_ok_r ? DIV_W'(rd_tile_r) : '0;
        div_req.divisor  = DVS_W'(div_rsp.quot[12:0]);
      end
      ST_TILE, ST_MUL, ST_SUM, ST_OUT: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Control and animation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_period_r <= 16'd100;
      loop_enable_r  <= 1'b1;
      sheet_width_r  <= 13'd256;
      sheet_height_r <= 13'd256;
      tile_width_r   <= 13'd32;
      tile_height_r  <= 13'd32;
      margin_x_r     <= 8'd0;
      margin_y_r     <= 8'd0;
      time_left_r    <= '0;
      frame_pos_r    <= '0;
      order_length_r <= 9'd1;
      playing_r      <= 1'b1;
      vld_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_PERIOD: frame_period_r <= cfg_wr_data;
          CFG_LOOP_ENABLE:  loop_enable_r  <= cfg_wr_data[0];
          CFG_SHEET_WIDTH:  sheet_width_r  <= cfg_wr_data[12:0];
          CFG_SHEET_HEIGHT: sheet_height_r <= cfg_wr_data[12:0];
          CFG_TILE_WIDTH:   tile_width_r   <= cfg_wr_data[12:0];
          CFG_TILE_HEIGHT:  tile_height_r  <= cfg_wr_data[12:0];
          CFG_MARGIN_X:     margin_x_r     <= cfg_wr_data[7:0];
          CFG_MARGIN_Y:     margin_y_r     <= cfg_wr_data[7:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        case (in_kind)
          KIND_TICK: begin
            if (in_visible && playing_r) begin
              time_left_r <= tl_new;
              if (tl_adv) begin
                if (!pos_end) begin
                  frame_pos_r <= frame_pos_r + 8'd1;
                end else if (loop_enable_r) begin
                  frame_pos_r <= '0;
                end else begin
                  playing_r   <= 1'b0;
                  frame_pos_r <= order_length_r[7:0] - 8'd1;
                end
              end
            end
          end
          KIND_LOAD: begin
            if (slot_ok) begin
              vld_r[in_entry_slot[AW-1:0]] <= 1'b1;
              if (in_entry_final) order_length_r <= {1'b0, in_entry_slot} + 9'd1;
            end
          end
          KIND_PLAY: playing_r <= 1'b1;
          KIND_STOP: playing_r <= 1'b0;
          KIND_RESTART: begin
            frame_pos_r <= '0;
            if (frame_period_r == '0) playing_r <= 1'b0;
          end
          default: ;
        endcase
      end

      // Hand the result over; drop it once the transfer completes
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame-order memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && is_load && slot_ok) begin
      order_mem[in_entry_slot[AW-1:0]] <= TILE_BITS'(in_entry_tile);
    end
    if (mem_rd) begin
      rd_tile_r <= order_mem[frame_pos_r[AW-1:0]];
      rd_ok_r   <= ({5'b0, frame_pos_r} < SLOT_LIM) && vld_r[frame_pos_r[AW-1:0]];
    end
  end

  // Tile position datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_READ && geom_bad) begin
      res_x_r <= '0;
      res_y_r <= '0;
    end
    if (state_r == ST_NX && div_rsp.done && nx_zero) begin
      res_x_r <= '0;
      res_y_r <= '0;
    end
    if (state_r == ST_TILE && div_rsp.done) begin
      tile_q_r <= div_rsp.quot;
      tile_r_r <= div_rsp.rem[12:0];
    end
    if (state_r == ST_MUL) begin
      x_prod_r <= {14'b0, tile_r_r} * {13'b0, dx};
      y_prod_r <= {14'b0, tile_q_r} * {16'b0, dy};
    end
    if (state_r == ST_SUM) begin
      res_x_r <= x_sum[12:0];
      res_y_r <= (y_sum > {8'b0, Y_MAX}) ? Y_MAX : y_sum[22:0];
    end
    if (state_r == ST_OUT && out_free) begin
      out_tile_x_r         <= res_x_r;
      out_tile_y_r         <= res_y_r;
      out_frame_position_r <= frame_pos_r;
      out_running_r        <= playing_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tile_x         = out_tile_x_r;
  assign out_tile_y         = out_tile_y_r;
  assign out_frame_position = out_frame_position_r;
  assign out_running        = out_running_r;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the sprite frame animator with a local prediction of every tile.
module tb;
  import sfa_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int MAX_PRINTS    = 40;
  localparam int SLOTS         = 256;
  localparam int TL_FLOOR      = -131072;

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    logic [15:0] period;
    logic        loop;
    logic [12:0] sheet_w;
    logic [12:0] sheet_h;
    logic [12:0] tile_w;
    logic [12:0] tile_h;
    logic [7:0]  margin_x;
    logic [7:0]  margin_y;
  } anim_cfg_t;

  typedef struct packed {
    logic [12:0] x;
    logic [22:0] y;
    logic [7:0]  pos;
    logic        run;
  } placement_t;

  localparam anim_cfg_t RESET_CFG = '{period: 16'd100, loop: 1'b1, sheet_w: 13'd256,
                                      sheet_h: 13'd256, tile_w: 13'd32, tile_h: 13'd32,
                                      margin_x: 8'd0, margin_y: 8'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_FRAME_PERIOD;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = KIND_TICK;
  logic [15:0] in_elapsed = '0;
  logic        in_visible = 1'b0;
  logic [7:0]  in_entry_slot = '0;
  logic [9:0]  in_entry_tile = '0;
  logic        in_entry_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_tile_x;
  logic [22:0] out_tile_y;
  logic [7:0]  out_frame_position;
  logic        out_running;

  // Predicted block state
  anim_cfg_t   p_cfg;
  int          p_time_left;
  logic [7:0]  p_pos;
  logic [8:0]  p_order_len;
  logic [9:0]  p_order [SLOTS];
  logic        p_playing;

  placement_t  expected_tiles [$];
  int          mismatches = 0;
  int          live_items = 0;
  int          burst_left = 0;
  bit          valid_held = 1'b0;
  int          cycles = 0;
  int          stall_mode = STALL_NONE;
  int          stall_left = 0;

  sprite_frame_animator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_elapsed         (in_elapsed),
    .in_visible         (in_visible),
    .in_entry_slot      (in_entry_slot),
    .in_entry_tile      (in_entry_tile),
    .in_entry_final     (in_entry_final),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tile_x         (out_tile_x),
    .out_tile_y         (out_tile_y),
    .out_frame_position (out_frame_position),
    .out_running        (out_running)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  // Receiver back-pressure: switch between no, half and heavy stalling at random
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HALF: out_stall <= ($urandom_range(0, 1) == 0);
      default:    out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("tb: %s mismatch at %0t: got %0d, expected %0d", what, $time, got, want);
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (out_valid && !out_stall) begin
      if (expected_tiles.size() == 0) begin
        report("unrequested result", out_frame_position, 0);
      end else begin
        want = expected_tiles.pop_front();
        if (out_tile_x !== want.x) report("tile_x", out_tile_x, want.x);
        if (out_tile_y !== want.y) report("tile_y", out_tile_y, want.y);
        if (out_frame_position !== want.pos)
          report("frame_position", out_frame_position, want.pos);
        if (out_running !== want.run) report("running", out_running, want.run);
      end
    end
  end

  function automatic placement_t tile_origin();
    placement_t r;
    longint     pitch_x, pitch_y, per_row, tile, yy;
    r = '0;
    r.pos = p_pos;
    r.run = p_playing;
    pitch_x = p_cfg.tile_w;
    pitch_x += p_cfg.margin_x;
    pitch_y = p_cfg.tile_h;
    pitch_y += p_cfg.margin_y;
    if (p_cfg.tile_w > p_cfg.sheet_w || p_cfg.tile_h > p_cfg.sheet_h) return r;
    if (pitch_x == 0) return r;
    per_row = p_cfg.sheet_w / pitch_x;
    if (per_row == 0) return r;
    tile = p_order[p_pos];
    r.x = 13'((tile % per_row) * pitch_x + p_cfg.margin_x);
    yy = (tile / per_row) * pitch_y + p_cfg.margin_y;
    r.y = (yy > longint'(Y_MAX)) ? Y_MAX : 23'(yy);
    return r;
  endfunction

  task automatic advance_animation(input logic [2:0] kind, input logic [15:0] elapsed,
                                   input logic visible, input logic [7:0] slot,
                                   input logic [9:0] tile, input logic last_entry);
    int t;
    live_items++;
    case (kind)
      KIND_TICK: if (visible) begin
        if (p_playing) begin
          t = p_time_left - int'(elapsed);
          if (t < TL_FLOOR) t = TL_FLOOR;
          if (t <= 0) begin
            t += int'(p_cfg.period);
            if (int'(p_pos) + 1 >= int'(p_order_len)) begin
              if (p_cfg.loop) begin
                p_pos = '0;
              end else begin
                p_playing = 1'b0;
                p_pos = 8'(p_order_len - 9'd1);
              end
            end else begin
              p_pos = p_pos + 8'd1;
            end
          end
          p_time_left = t;
        end
        expected_tiles.push_back(tile_origin());
      end
      KIND_LOAD: begin
        p_order[slot] = tile;
        if (last_entry) p_order_len = {1'b0, slot} + 9'd1;
      end
      KIND_PLAY: p_playing = 1'b1;
      KIND_STOP: p_playing = 1'b0;
      KIND_RESTART: begin
        p_pos = '0;
        if (p_cfg.period == '0) p_playing = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Offer one item, wait for its transfer, then maybe pause the sender
  task automatic send_item(input logic [2:0] kind, input logic [15:0] elapsed,
                           input logic visible, input logic [7:0] slot,
                           input logic [9:0] tile, input logic last_entry);
    int gap;
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_elapsed     <= elapsed;
    in_visible     <= visible;
    in_entry_slot  <= slot;
    in_entry_tile  <= tile;
    in_entry_final <= last_entry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_animation(kind, elapsed, visible, slot, tile, last_entry);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_held = 1'b1;
    end
  endtask

  task automatic tick(input logic [15:0] elapsed, input logic visible);
    send_item(KIND_TICK, elapsed, visible, 8'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic load(input logic [7:0] slot, input logic [9:0] tile, input logic last_entry);
    send_item(KIND_LOAD, 16'($urandom), 1'($urandom), slot, tile, last_entry);
  endtask

  // Other fields carry junk; the block must ignore them
  task automatic command(input logic [2:0] kind);
    send_item(kind, 16'($urandom), 1'($urandom), 8'($urandom), 10'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every result, then let any in-flight item finish
  task automatic settle();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    case (idx)
      CFG_FRAME_PERIOD: p_cfg.period   = value;
      CFG_LOOP_ENABLE:  p_cfg.loop     = value[0];
      CFG_SHEET_WIDTH:  p_cfg.sheet_w  = value[12:0];
      CFG_SHEET_HEIGHT: p_cfg.sheet_h  = value[12:0];
      CFG_TILE_WIDTH:   p_cfg.tile_w   = value[12:0];
      CFG_TILE_HEIGHT:  p_cfg.tile_h   = value[12:0];
      CFG_MARGIN_X:     p_cfg.margin_x = value[7:0];
      CFG_MARGIN_Y:     p_cfg.margin_y = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input anim_cfg_t c);
    settle();
    set_reg(CFG_FRAME_PERIOD, c.period);
    set_reg(CFG_LOOP_ENABLE, 16'(c.loop));
    set_reg(CFG_SHEET_WIDTH, 16'(c.sheet_w));
    set_reg(CFG_SHEET_HEIGHT, 16'(c.sheet_h));
    set_reg(CFG_TILE_WIDTH, 16'(c.tile_w));
    set_reg(CFG_TILE_HEIGHT, 16'(c.tile_h));
    set_reg(CFG_MARGIN_X, 16'(c.margin_x));
    set_reg(CFG_MARGIN_Y, 16'(c.margin_y));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    tick(16'd0, 1'b1);
    tick(16'hFFFF, 1'b0);
    tick(16'hFFFF, 1'b1);
  endtask

  task automatic test_order_and_controls();
    load(8'd255, 10'd0, 1'b1);
    load(8'd0, 10'd1023, 1'b0);
    load(8'd1, 10'd341, 1'b0);
    load(8'd2, 10'd682, 1'b0);
    load(8'd3, 10'd5, 1'b0);
    command(KIND_RESTART);
    tick(16'hFFFF, 1'b1);
    tick(16'hFFFF, 1'b1);
    tick(16'hFFFF, 1'b1);
    // shorten the order under the current position, read it frozen, then wrap
    load(8'd1, 10'd700, 1'b1);
    command(KIND_STOP);
    tick(16'd0, 1'b1);
    command(KIND_PLAY);
    tick(16'd0, 1'b1);
    command(KIND_RSVD_FIRST);
    command(KIND_RSVD_LAST);
  endtask

  task automatic test_geometry_limits();
    anim_cfg_t c;
    c = RESET_CFG;
    c.tile_w = 13'd4096;
    apply_config(c);
    tick(16'd0, 1'b1);
    c = RESET_CFG;
    c.tile_h = 13'd257;
    apply_config(c);
    tick(16'd0, 1'b1);
    // frame fits the sheet but the margin leaves no whole tile per row
    c = RESET_CFG;
    c.sheet_w  = 13'd32;
    c.tile_w   = 13'd32;
    c.margin_x = 8'd1;
    apply_config(c);
    tick(16'd0, 1'b1);
    c = '{period: 16'hFFFF, loop: 1'b0, sheet_w: 13'd4096, sheet_h: 13'd4096,
          tile_w: 13'd1, tile_h: 13'd1, margin_x: 8'd255, margin_y: 8'd255};
    apply_config(c);
    command(KIND_PLAY);
    tick(16'hFFFF, 1'b1);
    tick(16'hFFFF, 1'b1);
  endtask

  task automatic test_timer_limits();
    anim_cfg_t c;
    c = RESET_CFG;
    c.period = 16'd0;
    apply_config(c);
    command(KIND_RESTART);
    tick(16'd0, 1'b1);
    command(KIND_PLAY);
    tick(16'hFFFF, 1'b1);
    tick(16'hFFFF, 1'b1);
    tick(16'hFFFF, 1'b1);
  endtask

  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 13'd1;
      1:       return 13'd4096;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [12:0] pick_tile(input logic [12:0] sheet);
    int limit;
    if ($urandom_range(0, 7) == 0) return pick_size();
    limit = int'(sheet) / $urandom_range(1, 32);
    if (limit < 1) limit = 1;
    return 13'($urandom_range(1, limit));
  endfunction

  function automatic logic [7:0] pick_margin();
    case ($urandom_range(0, 7))
      0, 1:    return 8'd0;
      2:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic anim_cfg_t random_cfg();
    anim_cfg_t c;
    case ($urandom_range(0, 9))
      0:       c.period = 16'd0;
      1:       c.period = 16'hFFFF;
      default: c.period = 16'($urandom_range(1, 400));
    endcase
    c.loop     = ($urandom_range(0, 3) != 0);
    c.sheet_w  = pick_size();
    c.sheet_h  = pick_size();
    c.tile_w   = pick_tile(c.sheet_w);
    c.tile_h   = pick_tile(c.sheet_h);
    c.margin_x = pick_margin();
    c.margin_y = pick_margin();
    return c;
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int span;
    case ($urandom_range(0, 19))
      0, 1:    return 16'($urandom_range(0, 65535));
      2:       return 16'hFFFF;
      3:       return 16'd0;
      default: begin
        span = int'(p_cfg.period) * 2 + 1;
        if (span > 65535) span = 65535;
        return 16'($urandom_range(0, span));
      end
    endcase
  endfunction

  task automatic test_random_traffic();
    int   phase_end, len, pick;
    logic last_entry;
    while (live_items < RANDOM_ITEMS) begin
      apply_config(random_cfg());
      phase_end = live_items + $urandom_range(100, 200);
      while (live_items < phase_end && live_items < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // write a fresh frame order; now and then leave out the closing entry
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 12);
          for (int s = 0; s < len; s++) begin
            last_entry = (s == len - 1) && ($urandom_range(0, 5) != 0);
            load(8'(s), 10'($urandom_range(0, 1023)), last_entry);
          end
        end else if (pick < 12) begin
          command(KIND_PLAY);
        end else if (pick < 15) begin
          command(KIND_STOP);
        end else if (pick < 18) begin
          command(KIND_RESTART);
        end else if (pick < 20) begin
          command(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)));
        end else if (pick < 23) begin
          load(8'($urandom), 10'($urandom), 1'($urandom));
        end else begin
          tick(pick_elapsed(), $urandom_range(0, 7) != 0);
        end
      end
    end
  endtask

  initial begin
    p_cfg       = RESET_CFG;
    p_time_left = 0;
    p_pos       = '0;
    p_order_len = 9'd1;
    p_playing   = 1'b1;
    foreach (p_order[i]) p_order[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_order_and_controls();
    test_geometry_limits();
    test_timer_limits();
    test_random_traffic();
    settle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
